/* rtl/core/ktr_pkg.sv */
// ktr_pkg: shared types and constants for the keyed block transposition core
// holds the state encoding, controller/datapath command and status structs,
// and config register indexes; no dependencies
package ktr_pkg;

    localparam int MAX_KEY_LEN = 7;
    localparam int KEY_W       = 8 * MAX_KEY_LEN;
    localparam int POS_W       = $clog2(MAX_KEY_LEN + 1);

    localparam logic [7:0] PAD_BYTE = 8'h20;

    // config register indexes
    localparam logic [1:0] CFG_KEY_CHARS  = 2'd0;
    localparam logic [1:0] CFG_KEY_LENGTH = 2'd1;
    localparam logic [1:0] CFG_DIRECTION  = 2'd2;

    // direction codes
    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_RANK,
        ST_LOAD,
        ST_SHOW
    } ktr_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic rank;
        logic load_out;
    } ktr_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic flush;
        logic out_last;
    } ktr_status_t;

endpackage

/* rtl/core/ktr_ctrl.sv */
// ktr_ctrl: sequencer for the keyed block transposition core
// collects input beats, triggers the rank pass and paces the output beats
// depends on ktr_pkg
module ktr_ctrl
    import ktr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  ktr_status_t status,
    output ktr_cmd_t    cmd
);

    ktr_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT: begin
                if (s_tvalid && status.flush) begin
                    state_next = ST_RANK;
                end
            end
            ST_RANK: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                state_next = ST_SHOW;
            end
            ST_SHOW: begin
                if (m_tready && status.out_last) begin
                    state_next = ST_COLLECT;
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.rank     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_COLLECT: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_RANK: begin
                cmd.rank = 1'b1;
            end
            ST_LOAD: begin
                cmd.load_out = 1'b1;
            end
            ST_SHOW: begin
                m_tvalid     = 1'b1;
                cmd.load_out = m_tready && !status.out_last;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // input and output sides never open together
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_tready && m_tvalid))
        else $error("ktr_ctrl: input and output both active");

    // a rank pass is always followed by loading the first output byte
    assert property (@(posedge aclk) disable iff (!aresetn) cmd.rank |=> cmd.load_out)
        else $error("ktr_ctrl: rank pass not followed by output load");

    // a flushing capture starts the rank pass next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.capture && status.flush) |=> cmd.rank)
        else $error("ktr_ctrl: flush did not start rank pass");

endmodule

/* rtl/core/ktr_dp.sv */
// ktr_dp: datapath of the keyed block transposition core
// block buffer, fill count, key rank permutation and output register
// depends on ktr_pkg
module ktr_dp
    import ktr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  ktr_cmd_t          cmd,
    output ktr_status_t       status,
    input  logic [7:0]        in_byte,
    input  logic              in_eos,
    input  logic [KEY_W-1:0]  key_chars,
    input  logic [POS_W-1:0]  key_length,
    input  logic              direction,
    output logic [7:0]        out_byte,
    output logic              out_last
);

    logic [7:0]       blkbuf_reg [MAX_KEY_LEN];
    logic [7:0]       hold_reg   [MAX_KEY_LEN];
    logic [POS_W-1:0] src_reg    [MAX_KEY_LEN];
    logic [POS_W-1:0] src_next   [MAX_KEY_LEN];
    logic [POS_W-1:0] rank_w     [MAX_KEY_LEN];
    logic [POS_W-1:0] fill_reg, fill_next, fill_after;
    logic [POS_W-1:0] len_reg;
    logic [POS_W-1:0] idx_reg, idx_next;
    logic [POS_W-1:0] eff_len;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;

    // effective block length: zero reads as one
    always_comb begin
        eff_len = (key_length == '0) ? POS_W'(1) : key_length;
        if (eff_len > POS_W'(MAX_KEY_LEN)) begin
            eff_len = POS_W'(MAX_KEY_LEN);
        end
    end

    // fill count after taking this beat, and the flush decision
    always_comb begin
        fill_after = (fill_reg < POS_W'(MAX_KEY_LEN)) ? fill_reg + POS_W'(1) : fill_reg;
        status.flush    = (fill_after >= eff_len) || in_eos;
        status.out_last = out_last_reg;
    end

    // rank of each key position, ties broken by position
    always_comb begin
        logic [7:0]       ci;
        logic [7:0]       dj;
        logic [POS_W-1:0] cnt;
        for (int i = 0; i < MAX_KEY_LEN; i++) begin
            ci  = key_chars[8*i +: 8];
            cnt = '0;
            for (int j = 0; j < MAX_KEY_LEN; j++) begin
                dj = key_chars[8*j +: 8];
                if ((POS_W'(j) < eff_len) && ((dj < ci) || ((dj == ci) && (j < i)))) begin
                    cnt = cnt + POS_W'(1);
                end
            end
            rank_w[i] = cnt;
        end
    end

    // source position for each output position
    always_comb begin
        for (int k = 0; k < MAX_KEY_LEN; k++) begin
            src_next[k] = '0;
            if (direction == DIR_DECRYPT) begin
                src_next[k] = rank_w[k];
            end else begin
                for (int i = 0; i < MAX_KEY_LEN; i++) begin
                    if ((POS_W'(i) < eff_len) && (rank_w[i] == POS_W'(k))) begin
                        src_next[k] = POS_W'(i);
                    end
                end
            end
        end
    end

    // fill count and output index control
    always_comb begin
        fill_next = fill_reg;
        idx_next  = idx_reg;
        if (cmd.capture) begin
            fill_next = fill_after;
        end
        if (cmd.rank) begin
            fill_next = '0;
            idx_next  = '0;
        end else if (cmd.load_out) begin
            idx_next = idx_reg + POS_W'(1);
        end
    end

    // next output beat
    always_comb begin
        out_byte_next = out_byte_reg;
        out_last_next = out_last_reg;
        if (cmd.load_out) begin
            out_byte_next = hold_reg[src_reg[idx_reg]];
            out_last_next = (idx_reg == len_reg - POS_W'(1));
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            idx_reg      <= '0;
            out_last_reg <= 1'b0;
        end else begin
            fill_reg     <= fill_next;
            idx_reg      <= idx_next;
            out_last_reg <= out_last_next;
        end
    end

    // block buffer write
    always_ff @(posedge aclk) begin
        if (cmd.capture && (fill_reg < POS_W'(MAX_KEY_LEN))) begin
            blkbuf_reg[fill_reg] <= in_byte;
        end
    end

    // padded block, permutation and length snapshot
    always_ff @(posedge aclk) begin
        if (cmd.rank) begin
            len_reg <= eff_len;
            for (int i = 0; i < MAX_KEY_LEN; i++) begin
                hold_reg[i] <= (POS_W'(i) < fill_reg) ? blkbuf_reg[i] : PAD_BYTE;
                src_reg[i]  <= src_next[i];
            end
        end
    end

    // output byte register
    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
    end

    assign out_byte = out_byte_reg;
    assign out_last = out_last_reg;

    // rank pass empties the block
    assert property (@(posedge aclk) disable iff (!aresetn) cmd.rank |=> (fill_reg == '0))
        else $error("ktr_dp: fill count not cleared by rank pass");

endmodule

/* rtl/core/keyed_block_transposition.sv */
// keyed_block_transposition: columnar transposition of a byte stream by key rank
// the beat that completes a block is followed by the rank state and then the load
// state; the first output beat is valid in the show state that follows them
// a block of L bytes takes L input beats, the rank and load states, then L output beats
// (one per cycle while m_tready holds); input is closed while a block is emitted
// reset: aresetn clears fill count and control; key 0, length 1, encrypt
// instantiates ktr_ctrl and ktr_dp, depends on ktr_pkg
module keyed_block_transposition
    import ktr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // config write port
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [KEY_W-1:0] cfg_wdata,
    // input stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] in_byte
    input  logic             s_tlast,   // end_of_stream
    // output stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast    // block_end
);

    logic [KEY_W-1:0] key_chars_reg;
    logic [POS_W-1:0] key_length_reg;
    logic             direction_reg;
    ktr_cmd_t         cmd;
    ktr_status_t      status;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_chars_reg  <= '0;
            key_length_reg <= POS_W'(1);
            direction_reg  <= DIR_ENCRYPT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_KEY_CHARS:  key_chars_reg  <= cfg_wdata;
                CFG_KEY_LENGTH: key_length_reg <= cfg_wdata[POS_W-1:0];
                CFG_DIRECTION:  direction_reg  <= cfg_wdata[0];
                default:        key_chars_reg  <= key_chars_reg;
            endcase
        end
    end

    // sequencer
    ktr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    ktr_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .in_byte    (s_tdata),
        .in_eos     (s_tlast),
        .key_chars  (key_chars_reg),
        .key_length (key_length_reg),
        .direction  (direction_reg),
        .out_byte   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule
